// ===== rtl/ddo_pkg.sv =====
// Shared types, constants and helper functions of the differential-drive odometry block.
// No dependencies; every other file of the block imports this package.
package ddo_pkg;

  // Fixed-point format of positions, angles and velocities
  localparam int FRACTION_BITS = 16;
  // Rotation steps of the sine/cosine unit
  localparam int CORDIC_STEPS  = 16;
  localparam int ATAN_LEN      = 30;
  localparam int STEP_W        = $clog2(CORDIC_STEPS);
  // Low bits of the heading increment product that are kept
  localparam int HACC_W        = 32 + FRACTION_BITS;

  localparam logic [31:0] RAD_TO_UNITS = 32'd341782638;
  localparam logic [31:0] US_PER_S     = 32'd1000000;
  localparam logic [31:0] CORDIC_K     = 32'h26DD3B6A;

  // Configuration register indexes
  localparam int CFG_INDEX_W = 8;
  localparam logic [CFG_INDEX_W-1:0] REG_WHEEL_RADIUS     = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_WHEEL_SEPARATION = 8'd1;

  // Request to the shared divider
  typedef struct packed {
    logic        start;
    logic [6:0]  count;
    logic [63:0] dividend;
    logic [31:0] divisor;
  } ddo_div_req_t;

  // Sequencer states
  typedef enum logic [5:0] {
    S_IDLE, S_ND, S_NS, S_D1GO, S_D1W, S_HRM, S_HL, S_HH, S_HA, S_D2W,
    S_C1GO, S_C1W, S_MXL, S_MXH, S_MXA, S_MXU, S_MYL, S_MYH, S_MYA, S_MYU,
    S_LA, S_LB, S_LC, S_LD, S_LGO, S_LW, S_AA, S_AB, S_AC, S_AD, S_AW,
    S_AGO, S_AW2, S_QGO, S_QW, S_OUT
  } ddo_state_t;

  // Arctangent of 2^-i in binary-angle units (2^32 = 2*pi)
  function automatic logic [31:0] atan_units(input logic [4:0] i);
    logic [31:0] v;
    case (i)
      5'd0:  v = 32'h20000000;
      5'd1:  v = 32'h12E4051E;
      5'd2:  v = 32'h09FB385B;
      5'd3:  v = 32'h051111D4;
      5'd4:  v = 32'h028B0D43;
      5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E;
      5'd7:  v = 32'h00517C55;
      5'd8:  v = 32'h0028BE53;
      5'd9:  v = 32'h00145F2F;
      5'd10: v = 32'h000A2F98;
      5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;
      5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2FA;
      5'd15: v = 32'h0000517D;
      5'd16: v = 32'h000028BE;
      5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A30;
      5'd19: v = 32'h00000518;
      5'd20: v = 32'h0000028C;
      5'd21: v = 32'h00000146;
      5'd22: v = 32'h000000A3;
      5'd23: v = 32'h00000051;
      5'd24: v = 32'h00000029;
      5'd25: v = 32'h00000014;
      5'd26: v = 32'h0000000A;
      5'd27: v = 32'h00000005;
      5'd28: v = 32'h00000003;
      5'd29: v = 32'h00000001;
      default: v = 32'h0;
    endcase
    return v;
  endfunction

  // Clamp a CORDIC coordinate to [-1, 1] in Q2.30
  function automatic logic [31:0] clamp_q30(input logic signed [33:0] v);
    logic [31:0] r;
    if (v > 34'sd1073741824) begin
      r = 32'h4000_0000;
    end else if (v < -34'sd1073741824) begin
      r = 32'hC000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // Saturate a position sum to 32 bits
  function automatic logic [31:0] sat_pos(input logic signed [36:0] v);
    logic [31:0] r;
    if (v > 37'sd2147483647) begin
      r = 32'h7FFF_FFFF;
    end else if (v < -37'sd2147483648) begin
      r = 32'h8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // Apply a sign to a velocity magnitude and saturate to 32 bits
  function automatic logic [31:0] sat_rate(input logic [63:0] mag, input logic neg);
    logic [31:0] r;
    if (neg) begin
      r = (mag > 64'h8000_0000) ? 32'h8000_0000 : (~mag[31:0] + 32'd1);
    end else begin
      r = (mag > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/ddo_divider.sv =====
// Shared restoring divider, one quotient bit per cycle, 64-bit dividend, 32-bit divisor.
// Depends on ddo_pkg for the request struct.
module ddo_divider (
  input  logic                 clk,
  input  logic                 rst,
  input  ddo_pkg::ddo_div_req_t req,
  output logic                 busy,
  output logic [63:0]          quotient,
  output logic [31:0]          remainder
);
  import ddo_pkg::*;

  logic [31:0] rem;
  logic [63:0] quo;
  logic [31:0] dvs;
  logic [6:0]  cnt;
  logic [32:0] shifted;
  logic [32:0] trial;
  logic        fits;

  // Trial subtraction of the divisor from the shifted partial remainder
  always_comb begin
    shifted = {rem, quo[63]};
    trial   = shifted - {1'b0, dvs};
    fits    = shifted >= {1'b0, dvs};
  end

  // Hold busy while bits remain
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (req.start) begin
      busy <= 1'b1;
    end else if (busy && cnt == 7'd1) begin
      busy <= 1'b0;
    end
  end

  // Load the aligned dividend, then shift in one quotient bit a cycle
  always_ff @(posedge clk) begin
    if (req.start) begin
      quo <= req.dividend << (7'd64 - req.count);
      rem <= '0;
      dvs <= req.divisor;
      cnt <= req.count;
    end else if (busy) begin
      rem <= fits ? trial[31:0] : shifted[31:0];
      quo <= {quo[62:0], fits};
      cnt <= cnt - 7'd1;
    end
  end

  assign quotient  = quo;
  assign remainder = rem;

endmodule

// ===== rtl/ddo_cordic.sv =====
// Rotation-mode CORDIC, one step per cycle, giving Q2.30 cosine and sine of a binary angle.
// Depends on ddo_pkg for the arctangent table, step count and clamp.
module ddo_cordic (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] angle,
  output logic        busy,
  output logic [31:0] cos_q30,
  output logic [31:0] sin_q30
);
  import ddo_pkg::*;

  logic signed [33:0] x, y, x_next, y_next, xs, ys, xf, yf;
  logic signed [32:0] z, z_next, atan_s;
  logic               flip, flip_in;
  logic [31:0]        a_rot, a_adj;
  logic [STEP_W-1:0]  step;

  // Fold the angle into the right half plane
  always_comb begin
    a_rot   = angle + 32'h4000_0000;
    flip_in = a_rot[31];
    a_adj   = flip_in ? (angle + 32'h8000_0000) : angle;
  end

  // One micro-rotation
  always_comb begin
    xs     = x >>> step;
    ys     = y >>> step;
    atan_s = $signed({1'b0, atan_units(5'(step))});
    if (!z[32]) begin
      x_next = x - ys;
      y_next = y + xs;
      z_next = z - atan_s;
    end else begin
      x_next = x + ys;
      y_next = y - xs;
      z_next = z + atan_s;
    end
  end

  // Hold busy for the step count
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (busy && step == STEP_W'(CORDIC_STEPS - 1)) begin
      busy <= 1'b0;
    end
  end

  // Advance the vector
  always_ff @(posedge clk) begin
    if (start) begin
      x    <= 34'($signed(CORDIC_K));
      y    <= '0;
      z    <= $signed({a_adj[31], a_adj});
      flip <= flip_in;
      step <= '0;
    end else if (busy) begin
      x    <= x_next;
      y    <= y_next;
      z    <= z_next;
      step <= step + STEP_W'(1);
    end
  end

  // Undo the fold and clamp
  always_comb begin
    xf      = flip ? -x : x;
    yf      = flip ? -y : y;
    cos_q30 = clamp_q30(xf);
    sin_q30 = clamp_q30(yf);
  end

endmodule

// ===== rtl/diff_drive_odometry_core.sv =====
// Differential-drive odometry core: pose, yaw quaternion and body velocities from wheel angles.
// Depends on ddo_pkg, ddo_divider and ddo_cordic.
//
// One request is processed at a time; in_ready is high only while the core is idle, and the
// result is held on the output until it is taken. The time a request takes is set by the
// shared bit-serial divider (54, 49, 40 and two 64-bit divisions, the last three only when
// the time interval is nonzero), two 16-step CORDIC passes and the single shared multiplier
// that every product goes through. Configuration writes are always accepted and must only be
// made while the core is idle.
module diff_drive_odometry_core (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [ddo_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [31:0]                      cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic signed [31:0]               right_position,
  input  logic signed [31:0]               left_position,
  input  logic [31:0]                      stamp_us,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [31:0]               x_position,
  output logic signed [31:0]               y_position,
  output logic signed [31:0]               quat_z,
  output logic signed [31:0]               quat_w,
  output logic signed [31:0]               linear_vel,
  output logic signed [31:0]               angular_vel,
  output logic                             zero_interval
);
  import ddo_pkg::*;

  localparam int LQ_W = 53 - FRACTION_BITS;

  ddo_state_t state, state_next;

  logic [19:0]        radius, separation, sep_eff;
  logic [31:0]        right_prev, left_prev, prev_stamp, heading;
  logic signed [31:0] pos_x, pos_y;

  logic signed [33:0] diff, sum, ds;
  logic [31:0]        dt;
  logic signed [53:0] nd, ns;
  logic [53:0]        qa, nd_mag, ns_mag;
  logic [19:0]        ra, hrm, rm_calc;
  logic [HACC_W-1:0]  hq, hacc, q_calc, qa_ext, hsum;
  logic signed [65:0] acc;
  logic signed [66:0] p;
  logic signed [34:0] mul_a;
  logic signed [31:0] mul_b;
  logic [31:0]        quat_z_r, quat_w_r, lin_r, ang_r;
  logic               zero_r;

  logic [LQ_W-1:0]    qa_l;
  logic [FRACTION_BITS:0] ra_l;
  logic [63:0]        lq64, aq64;
  logic               lin_big, ang_big, nd_neg, ns_neg;
  logic signed [53:0] ds_shift;
  logic signed [33:0] ds_calc;
  logic signed [36:0] px_sum, py_sum;

  ddo_div_req_t       div_req;
  logic               div_busy;
  logic [63:0]        div_quo;
  logic [31:0]        div_rem;

  logic               cor_start, cor_busy;
  logic [31:0]        cor_angle, cor_cos, cor_sin;

  ddo_divider u_div (
    .clk       (clk),
    .rst       (rst),
    .req       (div_req),
    .busy      (div_busy),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  ddo_cordic u_cordic (
    .clk     (clk),
    .rst     (rst),
    .start   (cor_start),
    .angle   (cor_angle),
    .busy    (cor_busy),
    .cos_q30 (cor_cos),
    .sin_q30 (cor_sin)
  );

  // Derived operands
  always_comb begin
    sep_eff  = (separation == 20'd0) ? 20'd1 : separation;
    nd_neg   = nd[53];
    ns_neg   = ns[53];
    nd_mag   = nd_neg ? 54'(-nd) : 54'(nd);
    ns_mag   = ns_neg ? 54'(-ns) : 54'(ns);
    qa_l     = LQ_W'(ns_mag >> (FRACTION_BITS + 1));
    ra_l     = ns_mag[FRACTION_BITS:0];
    lq64     = 64'(qa_l);
    aq64     = 64'(qa);
    lin_big  = |lq64[63:44];
    ang_big  = |aq64[63:44];
    // floor quotient and nonnegative remainder of nd / sep
    qa_ext   = HACC_W'(div_quo[53:0]);
    if (nd_neg) begin
      q_calc  = (div_rem[19:0] != 20'd0) ? ~qa_ext : (~qa_ext + HACC_W'(1));
      rm_calc = (div_rem[19:0] != 20'd0) ? (sep_eff - div_rem[19:0]) : 20'd0;
    end else begin
      q_calc  = qa_ext;
      rm_calc = div_rem[19:0];
    end
    hsum     = hacc + HACC_W'(div_quo);
    ds_shift = ns >>> (FRACTION_BITS + 1);
    if (ds_shift > 54'sd8589934591) begin
      ds_calc = 34'sd8589934591;
    end else if (ds_shift < -54'sd8589934591) begin
      ds_calc = -34'sd8589934591;
    end else begin
      ds_calc = ds_shift[33:0];
    end
    px_sum = 37'(pos_x) + 37'(acc >>> 30);
    py_sum = 37'(pos_y) + 37'(acc >>> 30);
  end

  // Sequencer: next state and unit controls
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    mul_a      = '0;
    mul_b      = '0;
    div_req    = '0;
    cor_start  = 1'b0;
    cor_angle  = heading;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) state_next = S_ND;
      end
      S_ND: begin
        mul_a = 35'(diff);
        mul_b = $signed({12'd0, radius});
        state_next = S_NS;
      end
      S_NS: begin
        mul_a = 35'(sum);
        mul_b = $signed({12'd0, radius});
        state_next = S_D1GO;
      end
      S_D1GO: begin
        div_req.start    = 1'b1;
        div_req.count    = 7'd54;
        div_req.dividend = 64'(nd_mag);
        div_req.divisor  = 32'(sep_eff);
        state_next = S_D1W;
      end
      S_D1W: begin
        if (!div_busy) state_next = S_HRM;
      end
      S_HRM: begin
        mul_a = 35'(hrm);
        mul_b = $signed(RAD_TO_UNITS);
        state_next = S_HL;
      end
      S_HL: begin
        div_req.start    = 1'b1;
        div_req.count    = 7'd49;
        div_req.dividend = 64'(p[48:0]);
        div_req.divisor  = 32'(sep_eff);
        mul_a = 35'(hq[23:0]);
        mul_b = $signed(RAD_TO_UNITS);
        state_next = S_HH;
      end
      S_HH: begin
        mul_a = 35'(hq[HACC_W-1:24]);
        mul_b = $signed(RAD_TO_UNITS);
        state_next = S_HA;
      end
      S_HA: state_next = S_D2W;
      S_D2W: begin
        if (!div_busy) state_next = S_C1GO;
      end
      S_C1GO: begin
        cor_start  = 1'b1;
        cor_angle  = {heading[30:0], 1'b0};
        state_next = S_C1W;
      end
      S_C1W: begin
        if (!cor_busy) state_next = S_MXL;
      end
      S_MXL: begin
        mul_a = 35'(ds[16:0]);
        mul_b = $signed(cor_cos);
        state_next = S_MXH;
      end
      S_MXH: begin
        mul_a = 35'($signed(ds[33:17]));
        mul_b = $signed(cor_cos);
        state_next = S_MXA;
      end
      S_MXA: state_next = S_MXU;
      S_MXU: begin
        mul_a = 35'(ds[16:0]);
        mul_b = $signed(cor_sin);
        state_next = S_MYH;
      end
      S_MYL: state_next = S_MYH;
      S_MYH: begin
        mul_a = 35'($signed(ds[33:17]));
        mul_b = $signed(cor_sin);
        state_next = S_MYA;
      end
      S_MYA: state_next = S_MYU;
      S_MYU: state_next = zero_r ? S_QGO : S_LA;
      S_LA: begin
        mul_a = 35'(lq64[21:0]);
        mul_b = $signed(US_PER_S);
        state_next = S_LB;
      end
      S_LB: begin
        mul_a = 35'(lq64[43:22]);
        mul_b = $signed(US_PER_S);
        state_next = S_LC;
      end
      S_LC: begin
        mul_a = 35'(ra_l);
        mul_b = $signed(US_PER_S);
        state_next = S_LD;
      end
      S_LD: state_next = S_LGO;
      S_LGO: begin
        div_req.start    = 1'b1;
        div_req.count    = 7'd64;
        div_req.dividend = acc[63:0];
        div_req.divisor  = dt;
        state_next = S_LW;
      end
      S_LW: begin
        if (!div_busy) state_next = S_AA;
      end
      S_AA: begin
        mul_a = 35'(aq64[21:0]);
        mul_b = $signed(US_PER_S);
        state_next = S_AB;
      end
      S_AB: begin
        mul_a = 35'(aq64[43:22]);
        mul_b = $signed(US_PER_S);
        state_next = S_AC;
      end
      S_AC: begin
        mul_a = 35'(ra);
        mul_b = $signed(US_PER_S);
        state_next = S_AD;
      end
      S_AD: begin
        div_req.start    = 1'b1;
        div_req.count    = 7'd40;
        div_req.dividend = 64'(p[39:0]);
        div_req.divisor  = 32'(sep_eff);
        state_next = S_AW;
      end
      S_AW: begin
        if (!div_busy) state_next = S_AGO;
      end
      S_AGO: begin
        div_req.start    = 1'b1;
        div_req.count    = 7'd64;
        div_req.dividend = acc[63:0];
        div_req.divisor  = dt;
        state_next = S_AW2;
      end
      S_AW2: begin
        if (!div_busy) state_next = S_QGO;
      end
      S_QGO: begin
        cor_start  = 1'b1;
        cor_angle  = heading;
        state_next = S_QW;
      end
      S_QW: begin
        if (!cor_busy) state_next = S_OUT;
      end
      S_OUT: begin
        out_valid = 1'b1;
        if (out_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Shared multiplier, registered
  always_ff @(posedge clk) begin
    p <= 67'(mul_a) * 67'(mul_b);
  end

  // Configuration registers; writes to unknown indexes are dropped
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      radius     <= 20'd2163;
      separation <= 20'd11141;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_WHEEL_RADIUS:     radius     <= cfg_data[19:0];
        REG_WHEEL_SEPARATION: separation <= cfg_data[19:0];
        default: ;
      endcase
    end
  end

  // Odometry state: previous sample, heading and position
  always_ff @(posedge clk) begin
    if (rst) begin
      right_prev <= '0;
      left_prev  <= '0;
      prev_stamp <= '0;
      heading    <= '0;
      pos_x      <= '0;
      pos_y      <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            right_prev <= right_position;
            left_prev  <= left_position;
            prev_stamp <= stamp_us;
          end
        end
        S_D2W: begin
          if (!div_busy) heading <= heading + hsum[FRACTION_BITS+31:FRACTION_BITS];
        end
        S_MXU: pos_x <= sat_pos(px_sum);
        S_MYU: pos_y <= sat_pos(py_sum);
        default: ;
      endcase
    end
  end

  // Working registers of one request
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        diff   <= 34'(right_position) - 34'($signed(right_prev))
                - 34'(left_position) + 34'($signed(left_prev));
        sum    <= 34'(right_position) - 34'($signed(right_prev))
                + 34'(left_position) - 34'($signed(left_prev));
        dt     <= stamp_us - prev_stamp;
        zero_r <= (stamp_us == prev_stamp);
      end
      S_NS:   nd <= p[53:0];
      S_D1GO: ns <= p[53:0];
      S_D1W: begin
        if (!div_busy) begin
          qa  <= div_quo[53:0];
          ra  <= div_rem[19:0];
          hq  <= q_calc;
          hrm <= rm_calc;
        end
      end
      S_HA:   hacc <= hacc + {p[HACC_W-25:0], 24'd0};
      S_HH:   hacc <= p[HACC_W-1:0];
      S_C1GO: ds <= ds_calc;
      S_MXH, S_MYH, S_LB, S_AB: acc <= 66'(p);
      S_MXA, S_MYA: acc <= acc + (66'(p) <<< 17);
      S_LC, S_AC:   acc <= acc + (66'(p) <<< 22);
      S_LD:   acc <= acc + 66'(p >>> (FRACTION_BITS + 1));
      S_LW: begin
        if (!div_busy) lin_r <= sat_rate(lin_big ? 64'h1_0000_0000 : div_quo, ns_neg);
      end
      S_AW: begin
        if (!div_busy) acc <= acc + $signed(66'(div_quo));
      end
      S_AW2: begin
        if (!div_busy) ang_r <= sat_rate(ang_big ? 64'h1_0000_0000 : div_quo, nd_neg);
      end
      S_MYU: begin
        if (zero_r) begin
          lin_r <= '0;
          ang_r <= '0;
        end
      end
      S_QW: begin
        if (!cor_busy) begin
          quat_z_r <= cor_sin;
          quat_w_r <= cor_cos;
        end
      end
      default: ;
    endcase
  end

  // Result
  assign x_position    = pos_x;
  assign y_position    = pos_y;
  assign quat_z        = quat_z_r;
  assign quat_w        = quat_w_r;
  assign linear_vel    = lin_r;
  assign angular_vel   = ang_r;
  assign zero_interval = zero_r;

endmodule

// ===== rtl/ddo_checker.sv =====
// Port-level checks of the odometry core, attached by a bind statement below.
// Depends on ddo_pkg for the configuration index width.
module ddo_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            cfg_valid,
  input logic                            cfg_ready,
  input logic [ddo_pkg::CFG_INDEX_W-1:0] cfg_index,
  input logic [31:0]                     cfg_data,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic signed [31:0]              right_position,
  input logic signed [31:0]              left_position,
  input logic [31:0]                     stamp_us,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic signed [31:0]              x_position,
  input logic signed [31:0]              y_position,
  input logic signed [31:0]              quat_z,
  input logic signed [31:0]              quat_w,
  input logic signed [31:0]              linear_vel,
  input logic signed [31:0]              angular_vel,
  input logic                            zero_interval
);
  import ddo_pkg::*;

  // One request in flight: never take a request while a result waits
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid)) else $error("request taken while result pending");

  // Drop ready right after a request is taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready) else $error("ready held after accept");

  // Hold a stalled result (checked on x position, linear velocity and quaternion w)
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(x_position) && $stable(linear_vel)
    && $stable(quat_w)) else $error("stalled result changed");

  // Zero interval forces zero velocities
  a_zero_vel: assert property (@(posedge clk) disable iff (rst)
    out_valid && zero_interval |-> linear_vel == 32'sd0 && angular_vel == 32'sd0)
    else $error("velocity nonzero on zero interval");

  // Quaternion terms stay within unit range
  a_quat_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> quat_z <= 32'sd1073741824 && quat_z >= -32'sd1073741824
    && quat_w <= 32'sd1073741824 && quat_w >= -32'sd1073741824)
    else $error("quaternion out of range");

endmodule

bind diff_drive_odometry_core ddo_checker u_ddo_checker (.*);
